// ----- sv/lpcwr_pkg.sv -----
`default_nettype none

package lpcwr_pkg;

    // Cache geometry.
    localparam int PAGE_COUNT = 8;
    localparam int PAGE_BYTES = 512;

    // Field widths fixed by the interface.
    localparam int ADDR_W  = 24;
    localparam int ROM_W   = 25;
    localparam int WORD_W  = 16;
    localparam int SLOT_W  = 3;
    localparam int STAMP_W = 32;

    // Derived widths.
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int TAG_W  = ADDR_W - OFF_W;
    localparam int MEM_AW = SLOT_W + OFF_W;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;

    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_MISS  = 3'd1,
        ST_RANGE = 3'd2,
        ST_DONE  = 3'd3,
        ST_ERROR = 3'd4,
        ST_BUSY  = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        CMD_READ = 1'b0,
        CMD_FILL = 1'b1
    } t_cmd;

    typedef enum logic [CFG_AW-1:0] {
        REG_ROM_SIZE = 2'd0
    } t_reg_addr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RD_HI,
        S_RD_LO,
        S_RD_END,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/lru_page_cache_word_read.sv -----
`default_nettype none

// Fully associative read cache of ROM pages with timestamp LRU replacement.
// One input transfer carries either a word read (i_cmd = 0) or one page fill
// byte (i_cmd = 1); each read and each final or failed fill byte produces one
// output transfer, a non-final fill byte or a stray fill byte produces none.
// The block takes one item at a time and stalls its input until that item is
// finished. Out-of-range and busy reads skip the slot walk; a hit walks the
// slots up to the hit slot, because one tag and stamp comparator walks the
// slots one per cycle, and then reads the page RAM, which has a single
// registered port, once for each byte of the word; a miss walks all slots to
// pick the victim; the last fill byte also reads the word back from the RAM.
// Writing the ROM size register invalidates all pages, restarts the access
// clock and drops any pending fill.
module lru_page_cache_word_read
    import lpcwr_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    // Item input
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 i_cmd,
    input  wire  [ADDR_W-1:0]   i_byte_address,
    input  wire  [7:0]          i_fill_byte,
    input  wire                 i_fill_error,

    // Result output
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [2:0]          o_status,
    output logic [WORD_W-1:0]   o_word,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [ADDR_W-1:0]   o_fill_block_address,

    // Configuration port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [CFG_AW-1:0]   paddr,
    input  wire  [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    t_state r_state, n_state;

    // Configuration and cache directory.
    logic [ROM_W-1:0]   r_rom_bytes;
    logic [PAGE_COUNT-1:0] r_page_valid;
    logic [TAG_W-1:0]   r_page_tag   [PAGE_COUNT];
    logic [STAMP_W-1:0] r_page_stamp [PAGE_COUNT];
    logic [STAMP_W-1:0] r_access_clock;

    // Pending fill.
    logic               r_fill_pending;
    logic [SLOT_W-1:0]  r_fill_slot;
    logic [ADDR_W-1:0]  r_fill_req_addr;
    logic [OFF_W-1:0]   r_fill_count;

    // Page data RAM.
    logic [7:0]         r_page_data [PAGE_COUNT*PAGE_BYTES];
    logic [7:0]         r_mem_q;
    logic [7:0]         r_hi_byte;

    // Latched input item.
    logic               r_cmd;
    logic [ADDR_W-1:0]  r_addr;
    logic [7:0]         r_fbyte;
    logic               r_ferr;

    // Slot walk.
    logic [SLOT_W-1:0]  r_idx;
    logic               r_found_inv;
    logic [SLOT_W-1:0]  r_victim;
    logic [STAMP_W-1:0] r_min_stamp;

    // Word read-back address.
    logic [SLOT_W-1:0]  r_rd_slot;
    logic [OFF_W-1:0]   r_rd_off;

    // Pending result and output register.
    t_status            r_res_status;
    logic [WORD_W-1:0]  r_res_word;
    logic [SLOT_W-1:0]  r_res_slot;
    logic [ADDR_W-1:0]  r_res_blk;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [WORD_W-1:0]  r_out_word;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [ADDR_W-1:0]  r_out_blk;

    logic               in_xfer;
    logic               cfg_wr;
    logic               out_free;
    logic               is_range;
    logic               fill_last;
    logic               last_idx;
    logic               scan_valid;
    logic               scan_hit;
    logic               cand_found;
    logic [SLOT_W-1:0]  cand_victim;
    logic [STAMP_W-1:0] cand_min;
    logic               mem_rd_en;
    logic [MEM_AW-1:0]  mem_rd_addr;
    logic [ADDR_W-1:0]  fill_blk;
    logic [ROM_W:0]     addr_end;

    assign in_xfer  = i_in_valid && !o_in_stall;
    // Only a write to the ROM size register takes effect; other addresses are ignored.
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr == REG_ROM_SIZE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr == REG_ROM_SIZE) begin
            prdata = CFG_DW'(r_rom_bytes);
        end
    end

    // ROM size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bytes <= '0;
        end else if (cfg_wr) begin
            r_rom_bytes <= pwdata[ROM_W-1:0];
        end
    end

    // The word must end inside the ROM; the sum is one bit wider so it never wraps.
    assign addr_end  = (ROM_W+1)'(r_addr) + (ROM_W+1)'(2);
    assign is_range  = addr_end > {1'b0, r_rom_bytes};
    assign fill_last = (r_fill_count == OFF_W'(PAGE_BYTES - 1));
    assign fill_blk  = {r_fill_req_addr[ADDR_W-1:OFF_W], OFF_W'(0)};
    assign last_idx  = (r_idx == SLOT_W'(PAGE_COUNT - 1));

    // Shared compare unit: one slot's tag and stamp per cycle.
    always_comb begin
        scan_valid  = r_page_valid[r_idx];
        scan_hit    = scan_valid && (r_page_tag[r_idx] == r_addr[ADDR_W-1:OFF_W]);
        cand_found  = r_found_inv;
        cand_victim = r_victim;
        cand_min    = r_min_stamp;
        if (!r_found_inv) begin
            if (!scan_valid) begin
                cand_found  = 1'b1;
                cand_victim = r_idx;
            end else if (r_idx == '0 || r_page_stamp[r_idx] < r_min_stamp) begin
                cand_victim = r_idx;
                cand_min    = r_page_stamp[r_idx];
            end
        end
    end

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = {r_rd_slot, r_rd_off};
        case (r_state)
            S_RD_HI: begin
                mem_rd_en = 1'b1;
            end
            S_RD_LO: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = {r_rd_slot, r_rd_off + OFF_W'(1)};
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // Next state and input stall.
    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_cmd == CMD_READ) begin
                    if (r_fill_pending || is_range) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (!r_fill_pending) begin
                    n_state = S_IDLE;
                end else if (r_ferr) begin
                    n_state = S_EMIT;
                end else if (fill_last) begin
                    n_state = S_RD_HI;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_RD_HI;
                end else if (last_idx) begin
                    n_state = S_EMIT;
                end
            end
            S_RD_HI: begin
                n_state = S_RD_LO;
            end
            S_RD_LO: begin
                n_state = S_RD_END;
            end
            S_RD_END: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Page data RAM: one write port for fill bytes, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECODE && r_cmd == CMD_FILL && r_fill_pending && !r_ferr) begin
            r_page_data[{r_fill_slot, r_fill_count}] <= r_fbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_mem_q <= r_page_data[mem_rd_addr];
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd   <= i_cmd;
            r_addr  <= i_byte_address;
            r_fbyte <= i_fill_byte;
            r_ferr  <= i_fill_error;
        end
        if (r_state == S_RD_LO) begin
            r_hi_byte <= r_mem_q;
        end
        if (r_state == S_RD_END) begin
            r_res_word <= {r_hi_byte, r_mem_q};
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_status <= r_res_status;
            r_out_word   <= r_res_word;
            r_out_slot   <= r_res_slot;
            r_out_blk    <= r_res_blk;
        end
        case (r_state)
            S_DECODE: begin
                r_idx       <= '0;
                r_found_inv <= 1'b0;
                r_victim    <= '0;
                r_min_stamp <= '0;
                r_rd_slot   <= r_fill_slot;
                r_rd_off    <= r_fill_req_addr[OFF_W-1:0];
                r_res_slot  <= r_fill_slot;
                r_res_blk   <= fill_blk;
                r_res_word  <= {WORD_W{1'b1}};
                if (r_cmd == CMD_READ) begin
                    if (r_fill_pending) begin
                        r_res_status <= ST_BUSY;
                    end else begin
                        r_res_status <= ST_RANGE;
                        r_res_slot   <= '0;
                        r_res_blk    <= '0;
                    end
                end else if (r_ferr) begin
                    r_res_status <= ST_ERROR;
                end else begin
                    r_res_status <= ST_DONE;
                end
            end
            S_SCAN: begin
                r_idx       <= r_idx + SLOT_W'(1);
                r_found_inv <= cand_found;
                r_victim    <= cand_victim;
                r_min_stamp <= cand_min;
                r_rd_slot   <= r_idx;
                r_rd_off    <= r_addr[OFF_W-1:0];
                if (scan_hit) begin
                    r_res_status <= ST_HIT;
                    r_res_slot   <= r_idx;
                    r_res_blk    <= '0;
                end else begin
                    r_res_status <= ST_MISS;
                    r_res_word   <= '0;
                    r_res_slot   <= cand_victim;
                    r_res_blk    <= {r_addr[ADDR_W-1:OFF_W], OFF_W'(0)};
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Directory, access clock, fill tracking and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_page_valid    <= '0;
            r_access_clock  <= '0;
            r_fill_pending  <= 1'b0;
            r_fill_slot     <= '0;
            r_fill_req_addr <= '0;
            r_fill_count    <= '0;
            for (int i = 0; i < PAGE_COUNT; i++) begin
                r_page_tag[i]   <= {TAG_W{1'b1}};
                r_page_stamp[i] <= '0;
            end
        end else begin
            case (r_state)
                S_DECODE: begin
                    if (r_cmd == CMD_READ) begin
                        if (!r_fill_pending) begin
                            r_access_clock <= r_access_clock + STAMP_W'(1);
                        end
                    end else if (r_fill_pending) begin
                        if (r_ferr) begin
                            r_fill_pending <= 1'b0;
                            r_fill_count   <= '0;
                        end else if (fill_last) begin
                            r_fill_pending              <= 1'b0;
                            r_fill_count                <= '0;
                            r_page_valid[r_fill_slot]   <= 1'b1;
                            r_page_tag[r_fill_slot]     <= r_fill_req_addr[ADDR_W-1:OFF_W];
                            r_page_stamp[r_fill_slot]   <= r_access_clock;
                        end else begin
                            r_fill_count <= r_fill_count + OFF_W'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_page_stamp[r_idx] <= r_access_clock;
                    end else if (last_idx) begin
                        // Miss: the victim is dropped now and refilled byte by byte.
                        r_page_valid[cand_victim] <= 1'b0;
                        r_fill_pending            <= 1'b1;
                        r_fill_slot               <= cand_victim;
                        r_fill_req_addr           <= r_addr;
                        r_fill_count              <= '0;
                    end
                end
                default: begin
                    r_fill_count <= r_fill_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_word               = r_out_word;
    assign o_slot               = r_out_slot;
    assign o_fill_block_address = r_out_blk;

    // A slot being filled is never valid until its last byte arrives.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_pending |-> !r_page_valid[r_fill_slot])
        else $error("slot under fill is marked valid");

    // The slot walk only runs when no fill is outstanding.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !r_fill_pending)
        else $error("slot walk started with a fill pending");

    // An accepted item is always decoded in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == S_DECODE)
        else $error("accepted item not decoded");

    // A new result only appears from the result stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result presented outside the result stage");

endmodule

`default_nettype wire
